[sv/bls_pkg.sv]
// ----------------------------------------------------------------------------
// bls_pkg: shared types and constants for the bounded sorted list
// Holds the list depth, the operation codes of the request channel and the
// control word that the top level broadcasts to every list cell.
// ----------------------------------------------------------------------------
package bls_pkg;

    // Number of list cells and the width of a count that can reach it.
    localparam int LIST_DEPTH = 16;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    // Fixed field widths of the channels.
    localparam int DATA_W     = 32;
    localparam int OP_W       = 2;
    localparam int COUNT_W    = 5;

    // Operation codes carried by a request.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_HEAD     = 2'd0,
        OP_POP_HEAD      = 2'd1,
        OP_POP_TAIL      = 2'd2,
        OP_SORTED_INSERT = 2'd3
    } op_t;

    // What every cell does in the current cycle.
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_SHIFT_LEFT,
        CMD_INSERT
    } cell_cmd_t;

    // Control word broadcast along the chain.
    typedef struct packed {
        cell_cmd_t                 cmd;
        logic                      at_head;
        logic signed [DATA_W-1:0]  value;
    } cell_ctrl_t;

endpackage

[sv/bls_cell.sv]
// ----------------------------------------------------------------------------
// bls_cell: one position of the bounded sorted list
// Holds one entry, compares it with the value being inserted and takes its
// next entry from itself, its left neighbour, its right neighbour or the new
// value. A position chain tells each cell whether the insert point lies
// further towards the head.
// ----------------------------------------------------------------------------
module bls_cell (
    input  logic                            aclk,
    input  bls_pkg::cell_ctrl_t             ctrl,
    input  logic                            cell_valid,
    input  logic                            strict_cmp,
    input  logic signed [bls_pkg::DATA_W-1:0] left_entry,
    input  logic signed [bls_pkg::DATA_W-1:0] right_entry,
    input  logic                            found_in,
    output logic                            found_out,
    output logic signed [bls_pkg::DATA_W-1:0] entry
);
    import bls_pkg::*;

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     cmp_hit;
    logic                     stop_here;

    // The head moves aside only for a strictly smaller value; later cells
    // stop at the first entry not less than the value. Empty cells stop too.
    assign cmp_hit   = strict_cmp ? (entry_reg > ctrl.value) : (entry_reg >= ctrl.value);
    assign stop_here = ctrl.at_head || !cell_valid || cmp_hit;
    assign found_out = found_in || stop_here;

    // Next entry selection.
    always_comb begin
        entry_next = entry_reg;
        case (ctrl.cmd)
            CMD_SHIFT_LEFT: begin
                entry_next = right_entry;
            end
            CMD_INSERT: begin
                if (found_in) begin
                    entry_next = left_entry;
                end else if (stop_here) begin
                    entry_next = ctrl.value;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Entry storage; payload only, so no reset.
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

[sv/bounded_list_with_sorted_insert_unit.sv]
// ----------------------------------------------------------------------------
// bounded_list_with_sorted_insert_unit: bounded ordered list of signed values
// Keeps up to LIST_DEPTH entries in a row of cells, head in cell 0, and
// applies push head, pop head, pop tail and sorted insert requests.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake         | Payload
//  ---------+-----------+-------------------+------------------------------------
//  s_       | in        | s_valid / s_ready | s_operation, s_item_value
//  m_       | out       | m_valid / m_ready | m_head_value, m_list_empty,
//           |           |                   | m_entry_count, m_rejected
//
// One request is applied per cycle: every cell compares and shifts at once,
// and the insert point ripples along the cell chain within that cycle.
// The result appears in the cycle after acceptance and is read straight from the
// list state, so a new request is taken in the same cycle the result leaves.
// While a result waits unread, s_ready is low and the list holds.
// aresetn (synchronous, active low) empties the list; entries are not cleared.
// ----------------------------------------------------------------------------
module bounded_list_with_sorted_insert_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [bls_pkg::OP_W-1:0]          s_operation,
    input  logic signed [bls_pkg::DATA_W-1:0] s_item_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [bls_pkg::DATA_W-1:0] m_head_value,
    output logic                              m_list_empty,
    output logic [bls_pkg::COUNT_W-1:0]       m_entry_count,
    output logic                              m_rejected
);
    import bls_pkg::*;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     rejected_reg;
    logic                     rejected_next;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic                     s_fire;
    op_t                      op;
    cell_ctrl_t               ctrl;
    logic                     list_full;
    logic                     list_none;

    logic [LIST_DEPTH-1:0]    cell_valid;
    logic [LIST_DEPTH:0]      found_chain;
    logic signed [DATA_W-1:0] cell_entry [LIST_DEPTH];

    // Request handshake: the result register frees up when taken.
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign op        = op_t'(s_operation);
    assign list_full = (count_reg == CNT_W'(LIST_DEPTH));
    assign list_none = (count_reg == '0);

    // Decode the request into a cell command and the new count.
    always_comb begin
        ctrl.cmd      = CMD_HOLD;
        ctrl.at_head  = 1'b0;
        ctrl.value    = s_item_value;
        count_next    = count_reg;
        rejected_next = 1'b0;
        unique case (op)
            OP_PUSH_HEAD: begin
                if (list_full) begin
                    rejected_next = 1'b1;
                end else begin
                    ctrl.cmd     = CMD_INSERT;
                    ctrl.at_head = 1'b1;
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            OP_POP_HEAD: begin
                if (list_none) begin
                    rejected_next = 1'b1;
                end else begin
                    ctrl.cmd   = CMD_SHIFT_LEFT;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_POP_TAIL: begin
                if (list_none) begin
                    rejected_next = 1'b1;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_SORTED_INSERT: begin
                if (list_full) begin
                    rejected_next = 1'b1;
                end else begin
                    ctrl.cmd   = CMD_INSERT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            default: begin
                rejected_next = 1'b0;
            end
        endcase
        // Nothing moves unless a request is accepted.
        if (!s_fire) begin
            ctrl.cmd = CMD_HOLD;
        end
    end

    // Result valid tracking.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            rejected_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_fire) begin
                count_reg    <= count_next;
                rejected_reg <= rejected_next;
            end
        end
    end

    // Row of list cells; the insert point ripples from the head.
    assign found_chain[0] = 1'b0;

    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        logic signed [DATA_W-1:0] left_entry;
        logic signed [DATA_W-1:0] right_entry;

        assign cell_valid[i] = (CNT_W'(i) < count_reg);

        if (i == 0) begin : g_head
            assign left_entry = '0;
        end else begin : g_mid
            assign left_entry = cell_entry[i-1];
        end

        if (i == LIST_DEPTH - 1) begin : g_tail
            assign right_entry = '0;
        end else begin : g_body
            assign right_entry = cell_entry[i+1];
        end

        bls_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .cell_valid  (cell_valid[i]),
            .strict_cmp  (i == 0),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .found_in    (found_chain[i]),
            .found_out   (found_chain[i+1]),
            .entry       (cell_entry[i])
        );
    end

    // Results are read straight from the list state.
    assign m_valid       = m_valid_reg;
    assign m_head_value  = list_none ? '0 : cell_entry[0];
    assign m_list_empty  = list_none;
    assign m_entry_count = COUNT_W'(count_reg);
    assign m_rejected    = rejected_reg;

    // The count never passes the list depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("list count exceeds depth");

    // A rejected request leaves the count as it was.
    a_reject_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && rejected_next |=> count_reg == $past(count_reg))
        else $error("rejected request changed the count");

    // An accepted pop takes exactly one entry away.
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && !rejected_next && (op == OP_POP_HEAD || op == OP_POP_TAIL)
        |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("pop did not remove one entry");

    // An accepted insert always finds a place in the chain.
    a_insert_found: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.cmd == CMD_INSERT |-> found_chain[LIST_DEPTH])
        else $error("insert point not found");

endmodule
